FILE: rtl/core/dhat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhat_pkg
// shared codes and widths of the hit accumulate and trigger unit
// ----------------------------------------------------------------------------
package dhat_pkg;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned ENERGY_W   = 24;
  localparam int unsigned THRESH_W   = 24;
  localparam int unsigned AMP_W      = 16;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

  typedef enum logic [1:0] {
    OP_DEPOSIT = 2'd0,
    OP_READOUT = 2'd1,
    OP_CLEAR   = 2'd2
  } op_t;

  typedef enum logic [0:0] {
    REG_TDC_THRESHOLD = 1'b0,
    REG_ADC_THRESHOLD = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_EMIT  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

endpackage

FILE: rtl/core/dhat_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhat_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module dhat_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/daq_hit_accumulate_trigger_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daq_hit_accumulate_trigger_unit
// per detector and channel energy accumulator with readout and event trigger
// ----------------------------------------------------------------------------
// Deposits are taken one per cycle: the sum store is a registered-read ram
// updated by read, saturating add and write back, with the last written sum
// forwarded when two deposits hit the same entry back to back. A clear resets
// the touched flags (flip-flops), and an untouched entry reads as zero.
// A readout sweeps the ram once or twice, one entry per cycle: a scan of all
// DETECTORS*CHANNELS entries that builds the trigger and zeroes sums not above
// the adc threshold, then, only when triggered, an emit sweep of the same
// entries that streams the surviving sums; the emit sweep stalls while the
// output is held back by m_tready.
// Input is not taken while a readout is running.
// ----------------------------------------------------------------------------
module daq_hit_accumulate_trigger_unit
  import dhat_pkg::*;
#(
  parameter int unsigned DETECTORS = 4,
  parameter int unsigned CHANNELS  = 16,
  parameter int unsigned SUM_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_addr,
  input  logic [THRESH_W-1:0]   cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // detector_index, channel_index, amplitude, pad
  input  logic [1:0]            s_tuser,   // operation
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // out_detector, out_channel, energy_sum,
                                           // triggered, pad
  output logic [0:0]            m_tuser,   // hit_valid
  output logic                  m_tlast
);

  localparam int unsigned DEPTH = DETECTORS * CHANNELS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = (SUM_WIDTH > ENERGY_W) ? SUM_WIDTH : ENERGY_W;
  localparam logic [2:0]  DET_LIM  = 3'(DETECTORS);
  localparam logic [4:0]  CH_LIM   = 5'(CHANNELS);
  localparam logic [3:0]  CH_LAST  = 4'(CHANNELS - 1);
  localparam logic [AW-1:0] IDX_LAST = AW'(DEPTH - 1);

  state_t state;

  logic [THRESH_W-1:0]  tdc_threshold;
  logic [THRESH_W-1:0]  adc_threshold;
  logic [DEPTH-1:0]     touched;

  logic                 s1_valid;
  logic [AW-1:0]        s1_addr;
  logic [AMP_W-1:0]     s1_amp;
  logic                 fw_valid;
  logic [AW-1:0]        fw_addr;
  logic [SUM_WIDTH-1:0] fw_data;

  logic [AW-1:0]        idx;
  logic [1:0]           det_cnt;
  logic [3:0]           ch_cnt;
  logic                 issue_done;
  logic                 p_valid;
  logic [AW-1:0]        p_addr;
  logic [1:0]           p_det;
  logic [3:0]           p_ch;
  logic                 trig;

  logic                 hold_valid;
  logic [1:0]           hold_det;
  logic [3:0]           hold_ch;
  logic [SUM_WIDTH-1:0] hold_sum;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [SUM_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [SUM_WIDTH-1:0] ram_rdata;

  logic                 in_fire;
  logic [1:0]           in_det;
  logic [3:0]           in_ch;
  logic [AMP_W-1:0]     in_amp;
  logic                 in_range;
  logic                 dep_fire;
  logic [AW-1:0]        dep_addr;

  logic [SUM_WIDTH-1:0] s1_old;
  logic [SUM_WIDTH:0]   s1_add;
  logic [SUM_WIDTH-1:0] s1_sum;

  logic [SUM_WIDTH-1:0] p_val;
  logic [CW-1:0]        p_val_ext;
  logic                 p_over_tdc;
  logic                 p_over_adc;
  logic                 p_hit;
  logic                 need_push;
  logic                 out_free;
  logic                 stall;
  logic                 issue_en;
  logic                 sweep_done;
  logic                 trig_next;
  logic [CW-1:0]        hold_ext;
  logic [ENERGY_W-1:0]  hold_sat;

  dhat_ram #(
    .WIDTH (SUM_WIDTH),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign in_det   = s_tdata[1:0];
  assign in_ch    = s_tdata[5:2];
  assign in_amp   = s_tdata[21:6];
  assign in_range = ({1'b0, in_det} < DET_LIM) && ({1'b0, in_ch} < CH_LIM);
  assign dep_fire = in_fire && (s_tuser == OP_DEPOSIT) && in_range;
  assign dep_addr = AW'(32'(in_det) * 32'(CHANNELS) + 32'(in_ch));

  // read-modify-write of a deposit, with the previous write forwarded
  always_comb begin
    if (!touched[s1_addr]) begin
      s1_old = '0;
    end else if (fw_valid && (fw_addr == s1_addr)) begin
      s1_old = fw_data;
    end else begin
      s1_old = ram_rdata;
    end
    s1_add = {1'b0, s1_old} + (SUM_WIDTH + 1)'(s1_amp);
    s1_sum = s1_add[SUM_WIDTH] ? '1 : s1_add[SUM_WIDTH-1:0];
  end

  assign p_val      = touched[p_addr] ? ram_rdata : '0;
  assign p_val_ext  = CW'(p_val);
  assign p_over_tdc = p_val_ext > CW'(tdc_threshold);
  assign p_over_adc = p_val_ext > CW'(adc_threshold);
  assign p_hit      = p_valid && (p_val != '0);
  assign need_push  = p_hit && hold_valid;
  assign out_free   = !m_tvalid || m_tready;
  assign stall      = (state == ST_EMIT) && need_push && !out_free;
  assign trig_next  = trig || (p_valid && p_over_tdc);
  assign sweep_done = p_valid && issue_done && !stall;
  assign hold_ext   = CW'(hold_sum);
  assign hold_sat   = (hold_ext > CW'(ENERGY_MAX)) ? ENERGY_MAX : hold_ext[ENERGY_W-1:0];

  always_comb begin
    issue_en  = 1'b0;
    ram_raddr = idx;
    ram_we    = s1_valid;
    ram_waddr = s1_addr;
    ram_wdata = s1_sum;
    case (state)
      ST_IDLE: begin
        ram_raddr = dep_addr;
      end
      ST_SCAN: begin
        issue_en  = !issue_done;
        ram_we    = p_valid && touched[p_addr] && !p_over_adc;
        ram_waddr = p_addr;
        ram_wdata = '0;
      end
      ST_EMIT: begin
        issue_en  = !issue_done && !stall;
        ram_raddr = stall ? p_addr : idx;
      end
      ST_FLUSH: begin
        ram_raddr = idx;
      end
      default: begin
        ram_raddr = idx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tdc_threshold <= '0;
      adc_threshold <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TDC_THRESHOLD: tdc_threshold <= cfg_data;
        REG_ADC_THRESHOLD: adc_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      touched    <= '0;
      s1_valid   <= 1'b0;
      fw_valid   <= 1'b0;
      p_valid    <= 1'b0;
      issue_done <= 1'b0;
      idx        <= '0;
      det_cnt    <= '0;
      ch_cnt     <= '0;
      trig       <= 1'b0;
      hold_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      s1_valid <= dep_fire;
      fw_valid <= s1_valid;
      if (s1_valid) begin
        touched[s1_addr] <= 1'b1;
      end
      if (in_fire && (s_tuser == OP_CLEAR)) begin
        touched <= '0;
      end

      if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (!stall) begin
        p_valid <= issue_en;
      end
      if (issue_en) begin
        issue_done <= (idx == IDX_LAST);
        idx        <= idx + AW'(1);
        if (ch_cnt == CH_LAST) begin
          ch_cnt  <= '0;
          det_cnt <= det_cnt + 2'd1;
        end else begin
          ch_cnt  <= ch_cnt + 4'd1;
        end
      end

      case (state)
        ST_IDLE: begin
          if (in_fire && (s_tuser == OP_READOUT)) begin
            state      <= ST_SCAN;
            trig       <= 1'b0;
            idx        <= '0;
            det_cnt    <= '0;
            ch_cnt     <= '0;
            issue_done <= 1'b0;
          end
        end
        ST_SCAN: begin
          trig <= trig_next;
          if (sweep_done) begin
            state      <= trig_next ? ST_EMIT : ST_FLUSH;
            idx        <= '0;
            det_cnt    <= '0;
            ch_cnt     <= '0;
            issue_done <= 1'b0;
          end
        end
        ST_EMIT: begin
          if (need_push && out_free) begin
            m_tvalid <= 1'b1;
          end
          if (p_hit && !stall) begin
            hold_valid <= 1'b1;
          end
          if (sweep_done) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            hold_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (dep_fire) begin
      s1_addr <= dep_addr;
      s1_amp  <= in_amp;
    end
    fw_addr <= s1_addr;
    fw_data <= s1_sum;
    if (!stall) begin
      p_addr <= idx;
      p_det  <= det_cnt;
      p_ch   <= ch_cnt;
    end
    if ((state == ST_EMIT) && p_hit && !stall) begin
      hold_det <= p_det;
      hold_ch  <= p_ch;
      hold_sum <= p_val;
    end
    if ((state == ST_EMIT) && need_push && out_free) begin
      m_tuser <= 1'b1;
      m_tlast <= 1'b0;
      m_tdata <= {1'b0, 1'b1, hold_sat, hold_ch, hold_det};
    end else if ((state == ST_FLUSH) && out_free) begin
      m_tlast <= 1'b1;
      if (hold_valid) begin
        m_tuser <= 1'b1;
        m_tdata <= {1'b0, 1'b1, hold_sat, hold_ch, hold_det};
      end else begin
        m_tuser <= 1'b0;
        m_tdata <= {1'b0, trig, {ENERGY_W{1'b0}}, 4'd0, 2'd0};
      end
    end
  end

`ifndef SYNTH
  // the scan sweep writes the store, so no deposit may still be in flight
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !s1_valid)
    else $error("deposit write overlaps readout scan");

  // a buffered hit only exists while a triggered readout is emitting
  assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> ((state == ST_EMIT) || (state == ST_FLUSH)))
    else $error("hit buffer valid outside emit");

  // status items close the readout and carry no sum
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tlast && (m_tdata[29:0] == 30'd0)))
    else $error("malformed status transfer");

  // every hit comes from a triggered event
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> m_tdata[30])
    else $error("hit transfer without trigger");
`endif

endmodule

FILE: tb/sv/daq_hit_accumulate_trigger_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daq_hit_accumulate_trigger_unit_tb
// self-checking regression of the hit accumulate and trigger unit
// ----------------------------------------------------------------------------
// An in-bench model of the sum store, touched flags and both thresholds
// predicts the hits or status word of every readout. The checker compares
// each output transfer with the oldest prediction. Directed tests cover the
// empty store, field extremes, threshold edges and saturation. A pressure
// test holds the output off long enough to stall the input. Random event
// sequences then run under changing thresholds and random idling.
// ----------------------------------------------------------------------------
module daq_hit_accumulate_trigger_unit_tb;
  import dhat_pkg::*;

  localparam int          ENTRY_COUNT = 64;
  localparam int          IDLE_LIMIT  = 4000;
  localparam int          SETTLE      = 24;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam logic [23:0] THRESH_MAX  = 24'hFFFFFF;

  typedef struct packed {
    logic        hit;
    logic [1:0]  det;
    logic [3:0]  chan;
    logic [23:0] sum;
    logic        trig;
    logic        last;
  } readout_word_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [0:0]            cfg_addr;
  logic [THRESH_W-1:0]   cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // detector_index, channel_index, amplitude, pad
  logic [1:0]            s_tuser;   // operation
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // out_detector, out_channel, energy_sum, triggered, pad
  logic [0:0]            m_tuser;   // hit_valid
  logic                  m_tlast;

  // model state
  logic [23:0]   energy_acc [ENTRY_COUNT];
  bit            touched_flag [ENTRY_COUNT];
  logic [23:0]   tdc_level;
  logic [23:0]   adc_level;
  readout_word_t pending_words [$];

  int  errors;
  int  n_deposits, n_readouts, n_clears, n_ignored, n_hits, n_status, n_cfg;
  bit  tx_idle_en;
  bit  rx_idle_en;
  int  rx_hold_req;
  int  idle_cycles;

  daq_hit_accumulate_trigger_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // model of the store

  task automatic accumulate_deposit(logic [1:0] det, logic [3:0] chan, logic [15:0] amp);
    int   idx;
    logic [24:0] total;
    idx   = det * 16 + chan;
    total = energy_acc[idx] + amp;
    energy_acc[idx]   = total[24] ? ENERGY_MAX : total[23:0];
    touched_flag[idx] = 1'b1;
  endtask

  task automatic sweep_readout();
    bit            fired;
    readout_word_t word;
    readout_word_t hits [$];
    fired = 1'b0;
    for (int idx = 0; idx < ENTRY_COUNT; idx++) begin
      if (touched_flag[idx]) begin
        if (energy_acc[idx] > tdc_level) fired = 1'b1;
        if (!(energy_acc[idx] > adc_level)) energy_acc[idx] = '0;
        if (energy_acc[idx] != 0) begin
          word.hit  = 1'b1;
          word.det  = 2'(idx / 16);
          word.chan = 4'(idx % 16);
          word.sum  = energy_acc[idx];
          word.trig = 1'b1;
          word.last = 1'b0;
          hits.insert(hits.size(), word);
        end
      end
    end
    if (fired && hits.size() > 0) begin
      hits[hits.size()-1].last = 1'b1;
      foreach (hits[k]) pending_words.insert(pending_words.size(), hits[k]);
      n_hits += hits.size();
    end else begin
      word      = '0;
      word.trig = fired;
      word.last = 1'b1;
      pending_words.insert(pending_words.size(), word);
      n_status++;
    end
  endtask

  task automatic clear_touched();
    for (int idx = 0; idx < ENTRY_COUNT; idx++) begin
      if (touched_flag[idx]) begin
        energy_acc[idx]   = '0;
        touched_flag[idx] = 1'b0;
      end
    end
  endtask

  // input side

  task automatic send_item(logic [1:0] op, logic [1:0] det, logic [3:0] chan,
                           logic [15:0] amp);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, amp, chan, det};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    case (op)
      OP_DEPOSIT: begin
        accumulate_deposit(det, chan, amp);
        n_deposits++;
      end
      OP_READOUT: begin
        sweep_readout();
        n_readouts++;
      end
      OP_CLEAR: begin
        clear_touched();
        n_clears++;
      end
      default: n_ignored++;
    endcase
  endtask

  task automatic deposit(logic [1:0] det, logic [3:0] chan, logic [15:0] amp);
    send_item(OP_DEPOSIT, det, chan, amp);
  endtask

  task automatic command(logic [1:0] op);
    send_item(op, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
              16'($urandom_range(0, 65535)));
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [23:0] value);
    drain_results();
    repeat (SETTLE) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TDC_THRESHOLD) tdc_level = value;
    else adc_level = value;
    n_cfg++;
  endtask

  // output side

  initial begin : result_sink
    int stall;
    int hold;
    stall = 0;
    hold  = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) stall = rx_idle_en ? $urandom_range(0, 7) : 0;
      if (rx_hold_req > 0) begin
        hold        = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    readout_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_words.size() == 0) begin
        $error("result transfer with none pending: tdata %h tuser %b tlast %b",
               m_tdata, m_tuser, m_tlast);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (m_tuser[0] !== want.hit) begin
          $error("hit_valid: expected %0d, got %0d", want.hit, m_tuser[0]);
          errors++;
        end
        if (m_tdata[1:0] !== want.det) begin
          $error("out_detector: expected %0d, got %0d", want.det, m_tdata[1:0]);
          errors++;
        end
        if (m_tdata[5:2] !== want.chan) begin
          $error("out_channel: expected %0d, got %0d", want.chan, m_tdata[5:2]);
          errors++;
        end
        if (m_tdata[29:6] !== want.sum) begin
          $error("energy_sum: expected %0d, got %0d", want.sum, m_tdata[29:6]);
          errors++;
        end
        if (m_tdata[30] !== want.trig) begin
          $error("triggered: expected %0d, got %0d", want.trig, m_tdata[30]);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("daq_hit_accumulate_trigger_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // tests

  task automatic test_empty_store();
    command(OP_READOUT);
    deposit(2'd1, 4'd7, 16'd0);
    command(OP_READOUT);
    command(OP_CLEAR);
  endtask

  task automatic test_field_extremes();
    deposit(2'd0, 4'd0, 16'hFFFF);
    deposit(2'd3, 4'd15, 16'hFFFF);
    deposit(2'd1, 4'd10, 16'h5555);
    deposit(2'd2, 4'd5, 16'hAAAA);
    deposit(2'd2, 4'd5, 16'h0001);
    command(OP_UNUSED);
    command(OP_READOUT);
    command(OP_READOUT);
    command(OP_CLEAR);
    command(OP_READOUT);
  endtask

  task automatic test_threshold_edges();
    write_reg(REG_TDC_THRESHOLD, 24'd1000);
    write_reg(REG_ADC_THRESHOLD, 24'd1000);
    deposit(2'd0, 4'd1, 16'd1000);
    deposit(2'd0, 4'd2, 16'd1001);
    command(OP_READOUT);
    command(OP_READOUT);
    // nothing can pass the top tdc level
    write_reg(REG_TDC_THRESHOLD, THRESH_MAX);
    write_reg(REG_ADC_THRESHOLD, 24'd0);
    command(OP_READOUT);
    // triggered but every sum zeroed
    write_reg(REG_TDC_THRESHOLD, 24'd0);
    write_reg(REG_ADC_THRESHOLD, THRESH_MAX);
    command(OP_READOUT);
    command(OP_READOUT);
    command(OP_CLEAR);
    write_reg(REG_ADC_THRESHOLD, 24'd0);
  endtask

  task automatic test_saturation();
    tx_idle_en = 1'b0;
    // just below the top of the sum range
    for (int k = 0; k < 256; k++) deposit(2'd2, 4'd9, 16'hFFFF);
    deposit(2'd2, 4'd10, 16'hFFFF);
    command(OP_READOUT);
    deposit(2'd2, 4'd9, 16'hFFFF);
    command(OP_READOUT);
    command(OP_CLEAR);
    tx_idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    drain_results();
    tx_idle_en  = 1'b0;
    rx_hold_req = 300;
    for (int k = 0; k < 12; k++) deposit(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                                         16'($urandom_range(1, 65535)));
    command(OP_READOUT);
    for (int k = 0; k < 4; k++) deposit(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                                        16'($urandom_range(1, 65535)));
    command(OP_READOUT);
    // sender waits for all results before going on
    drain_results();
    command(OP_READOUT);
    command(OP_CLEAR);
    tx_idle_en = 1'b1;
  endtask

  task automatic new_phase();
    logic [23:0] tdc_val;
    logic [23:0] adc_val;
    case ($urandom_range(0, 5))
      0: begin
        tdc_val = 24'd0;
        adc_val = 24'd0;
      end
      1: begin
        tdc_val = THRESH_MAX;
        adc_val = 24'($urandom_range(0, 100000));
      end
      2: begin
        tdc_val = 24'($urandom_range(0, 100000));
        adc_val = THRESH_MAX;
      end
      3: begin
        tdc_val = 24'($urandom_range(0, 24'hFFFFFF));
        adc_val = 24'($urandom_range(0, 24'hFFFFFF));
      end
      default: begin
        tdc_val = 24'($urandom_range(0, 400000));
        adc_val = 24'($urandom_range(0, 150000));
      end
    endcase
    write_reg(REG_TDC_THRESHOLD, tdc_val);
    write_reg(REG_ADC_THRESHOLD, adc_val);
    tx_idle_en = ($urandom_range(0, 3) != 0);
    rx_idle_en = ($urandom_range(0, 3) != 0);
  endtask

  task automatic test_random_events(int target);
    int          sent;
    int          next_phase;
    int          roll;
    int          burst;
    logic [1:0]  hot_det;
    logic [15:0] amp;
    sent       = 0;
    next_phase = 0;
    hot_det    = '0;
    while (sent < target) begin
      if (sent >= next_phase) begin
        new_phase();
        hot_det    = 2'($urandom_range(0, 3));
        next_phase = sent + 12;
      end
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        burst = $urandom_range(1, 6);
        for (int k = 0; k < burst; k++) begin
          case ($urandom_range(0, 9))
            0: amp = 16'd0;
            1: amp = 16'hFFFF;
            default: amp = 16'($urandom_range(0, 65535));
          endcase
          if ($urandom_range(0, 1)) deposit(hot_det, 4'($urandom_range(0, 3)), amp);
          else deposit(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), amp);
        end
        sent += burst;
        if ($urandom_range(0, 99) < 85) begin
          command(OP_READOUT);
          sent++;
        end
        if ($urandom_range(0, 99) < 30) begin
          command(OP_CLEAR);
          sent++;
        end
      end else if (roll < 85) begin
        command(OP_CLEAR);
        sent++;
      end else if (roll < 94) begin
        command(OP_READOUT);
        sent++;
      end else begin
        command(OP_UNUSED);
      end
    end
  endtask

  initial begin
    errors      = 0;
    n_deposits  = 0;
    n_readouts  = 0;
    n_clears    = 0;
    n_ignored   = 0;
    n_hits      = 0;
    n_status    = 0;
    n_cfg       = 0;
    tx_idle_en  = 1'b1;
    rx_idle_en  = 1'b1;
    rx_hold_req = 0;
    idle_cycles = 0;
    tdc_level   = '0;
    adc_level   = '0;
    for (int idx = 0; idx < ENTRY_COUNT; idx++) begin
      energy_acc[idx]   = '0;
      touched_flag[idx] = 1'b0;
    end
    rst      <= 1'b1;
    cfg_we   <= 1'b0;
    cfg_addr <= '0;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_empty_store();
    test_field_extremes();
    test_threshold_edges();
    test_saturation();
    test_backpressure();
    test_random_events(24);

    drain_results();
    repeat (160) @(posedge clk);
    if (pending_words.size() != 0) begin
      $error("%0d result transfers never arrived", pending_words.size());
      errors++;
    end
    $display("covered %0d deposits, %0d readouts, %0d clears, %0d ignored ops",
             n_deposits, n_readouts, n_clears, n_ignored);
    $display("checked %0d hit and %0d status transfers over %0d threshold writes",
             n_hits, n_status, n_cfg);
    if (errors == 0) begin
      $display("daq_hit_accumulate_trigger_unit regression: pass");
    end else begin
      $display("daq_hit_accumulate_trigger_unit regression: fail");
    end
    $finish;
  end

endmodule
